>>> hw/rtl/overwriting_ring_with_offset_search_assert.svh
// assertion macros used by the overwriting ring datapath
`ifndef OVERWRITING_RING_WITH_OFFSET_SEARCH_ASSERT_SVH
`define OVERWRITING_RING_WITH_OFFSET_SEARCH_ASSERT_SVH

// condition holds at every clock edge out of reset
`define ORWS_ASSERT_ALWAYS(lbl, clk_s, rst_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (cond)) \
    else $error("orws assertion failed");

// antecedent implies consequent on the following edge
`define ORWS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("orws assertion failed");

`endif

>>> hw/rtl/orws_pkg.sv
// shared types and constants of the overwriting ring with offset search
`timescale 1ns / 1ps

package orws_pkg;

  // default ring depth
  localparam int SLOTS_DEFAULT = 16;

  // field widths
  localparam int HANDLE_W   = 32;
  localparam int SIZE_W     = 16;
  localparam int OFFSET_W   = 20;
  localparam int SLOT_IDX_W = 4;

  // action codes
  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_FIND = 1'b1;

  // input word
  typedef struct packed {
    logic                action;
    logic [HANDLE_W-1:0] entry_handle;
    logic [SIZE_W-1:0]   entry_size;
    logic [OFFSET_W-1:0] seek_offset;
  } in_word_t;

  // result word
  typedef struct packed {
    logic                  found;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [HANDLE_W-1:0]   found_handle;
    logic [SIZE_W-1:0]     found_size;
    logic [SIZE_W-1:0]     byte_in_entry;
  } out_word_t;

  // controller to datapath commands
  typedef struct packed {
    logic add;
    logic find_start;
    logic walk;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic hit;
    logic miss;
  } dp_status_t;

endpackage

>>> hw/rtl/orws_in_if.sv
// input channel interface: valid, ready and the request word fields
`timescale 1ns / 1ps

interface orws_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [orws_pkg::HANDLE_W-1:0] entry_handle;
  logic [orws_pkg::SIZE_W-1:0]   entry_size;
  logic [orws_pkg::OFFSET_W-1:0] seek_offset;

  modport source (output valid, action, entry_handle, entry_size, seek_offset,
                  input ready);
  modport sink (input valid, action, entry_handle, entry_size, seek_offset,
                output ready);
endinterface

>>> hw/rtl/orws_out_if.sv
// result channel interface: valid, ready and the result word fields
`timescale 1ns / 1ps

interface orws_out_if;
  logic                            valid;
  logic                            ready;
  logic                            found;
  logic [orws_pkg::SLOT_IDX_W-1:0] slot_index;
  logic [orws_pkg::HANDLE_W-1:0]   found_handle;
  logic [orws_pkg::SIZE_W-1:0]     found_size;
  logic [orws_pkg::SIZE_W-1:0]     byte_in_entry;

  modport source (output valid, found, slot_index, found_handle, found_size,
                  byte_in_entry, input ready);
  modport sink (input valid, found, slot_index, found_handle, found_size,
                byte_in_entry, output ready);
endinterface

>>> hw/rtl/orws_datapath.sv
// ring datapath: pointers, slot memory, offset walk and result registers
`timescale 1ns / 1ps
`include "overwriting_ring_with_offset_search_assert.svh"

module orws_datapath #(
  parameter int SLOTS = orws_pkg::SLOTS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  orws_pkg::in_word_t    in_word,
  input  orws_pkg::dp_cmd_t     cmd,
  output orws_pkg::dp_status_t  status,
  output orws_pkg::out_word_t   out_word
);
  import orws_pkg::*;

  localparam int PTR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int ACC_W = (SIZE_W + CNT_W > OFFSET_W) ? SIZE_W + CNT_W : OFFSET_W;
  localparam logic [PTR_W-1:0]   LAST_SLOT = PTR_W'(SLOTS - 1);
  localparam logic [CNT_W:0]     SLOTS_WIDE = (CNT_W + 1)'(SLOTS);
  localparam logic [CNT_W-1:0]   SLOTS_CNT = CNT_W'(SLOTS);

  function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
  endfunction

  // ring pointers
  logic [PTR_W-1:0] wp_r, rp_r;
  logic             full_r;

  // slot memory
  logic [HANDLE_W-1:0] mem_handle [SLOTS];
  logic [SIZE_W-1:0]   mem_size   [SLOTS];

  // walk state
  logic [PTR_W-1:0]    issue_idx_r;
  logic [CNT_W-1:0]    issue_left_r;
  logic [PTR_W-1:0]    rd_idx_r;
  logic                rd_vld_r;
  logic [HANDLE_W-1:0] rd_handle_r;
  logic [SIZE_W-1:0]   rd_size_r;
  logic [OFFSET_W-1:0] offset_r;
  logic [ACC_W-1:0]    base_r;

  // result and output registers
  out_word_t res_r, out_r;

  logic [CNT_W:0]              wrap_sum;
  logic [CNT_W-1:0]            count;
  logic [ACC_W-1:0]            end_sum;
  logic [ACC_W-1:0]            diff;
  logic                        in_range;
  logic [SLOT_IDX_W+PTR_W-1:0] idx_ext;
  out_word_t                   hit_word;

  // occupied slot count
  always_comb begin
    wrap_sum = (CNT_W + 1)'(wp_r) + SLOTS_WIDE - (CNT_W + 1)'(rp_r);
    if (full_r) begin
      count = SLOTS_CNT;
    end else if (wp_r >= rp_r) begin
      count = CNT_W'(wp_r - rp_r);
    end else begin
      count = wrap_sum[CNT_W-1:0];
    end
  end

  // compare stage of the walk
  always_comb begin
    end_sum  = base_r + ACC_W'(rd_size_r);
    diff     = ACC_W'(offset_r) - base_r;
    in_range = ACC_W'(offset_r) < end_sum;
    idx_ext  = {{SLOT_IDX_W{1'b0}}, rd_idx_r};
    status.hit  = rd_vld_r && in_range;
    status.miss = (issue_left_r == '0) && (!rd_vld_r || !in_range);
    hit_word.found         = 1'b1;
    hit_word.slot_index    = idx_ext[SLOT_IDX_W-1:0];
    hit_word.found_handle  = rd_handle_r;
    hit_word.found_size    = rd_size_r;
    hit_word.byte_in_entry = diff[SIZE_W-1:0];
  end

  // pointer update on add
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      full_r <= 1'b0;
    end else if (cmd.add) begin
      wp_r <= wrap_next(wp_r);
      if (full_r) begin
        rp_r <= wrap_next(rp_r);
      end
      full_r <= full_r | (wrap_next(wp_r) == rp_r);
    end
  end

  // slot memory write port
  always_ff @(posedge clk) begin
    if (cmd.add) begin
      mem_handle[wp_r] <= in_word.entry_handle;
      mem_size[wp_r]   <= in_word.entry_size;
    end
  end

  // slot memory read port
  always_ff @(posedge clk) begin
    rd_handle_r <= mem_handle[issue_idx_r];
    rd_size_r   <= mem_size[issue_idx_r];
  end

  // walk sequencing, one slot issued per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r     <= 1'b0;
      issue_left_r <= '0;
    end else if (cmd.find_start) begin
      issue_idx_r  <= rp_r;
      issue_left_r <= count;
      rd_vld_r     <= 1'b0;
      base_r       <= '0;
      offset_r     <= in_word.seek_offset;
    end else if (cmd.walk) begin
      rd_vld_r <= (issue_left_r != '0);
      rd_idx_r <= issue_idx_r;
      if (issue_left_r != '0) begin
        issue_idx_r  <= wrap_next(issue_idx_r);
        issue_left_r <= issue_left_r - CNT_W'(1);
      end
      if (rd_vld_r) begin
        base_r <= end_sum;
      end
    end
  end

  // result capture and output register
  always_ff @(posedge clk) begin
    if (cmd.add) begin
      res_r <= '0;
    end else if (cmd.walk && status.hit) begin
      res_r <= hit_word;
    end else if (cmd.walk && status.miss) begin
      res_r <= '0;
    end
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  assign out_word = out_r;

  // a full ring stays full and keeps its pointers together; hit and miss never coincide
  `ORWS_ASSERT_NEXT(a_full_sticky, clk, rst_n, full_r, full_r)
  `ORWS_ASSERT_ALWAYS(a_full_ptrs, clk, rst_n, !full_r || (wp_r == rp_r))
  `ORWS_ASSERT_ALWAYS(a_hit_miss_excl, clk, rst_n, !(status.hit && status.miss))

endmodule

>>> hw/rtl/orws_ctrl.sv
// ring controller: accepts words, sequences the walk and loads the output
`timescale 1ns / 1ps

module orws_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_action,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output orws_pkg::dp_cmd_t    cmd,
  input  orws_pkg::dp_status_t status
);
  import orws_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_POST
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  // commands to the datapath
  always_comb begin
    accept         = (state_r == ST_IDLE) && in_valid;
    out_free       = !out_valid_r || out_ready;
    cmd.add        = accept && (in_action == ACT_ADD);
    cmd.find_start = accept && (in_action == ACT_FIND);
    cmd.walk       = (state_r == ST_WALK);
    cmd.out_load   = (state_r == ST_POST) && out_free;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.add) begin
          state_nxt = ST_POST;
        end else if (cmd.find_start) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (status.hit || status.miss) begin
          state_nxt = ST_POST;
        end
      end
      ST_POST: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> hw/rtl/overwriting_ring_with_offset_search.sv
// top level of the overwriting ring with offset search
//
//   channel  dir  handshake      word
//   in_ch    in   valid/ready    action, entry_handle, entry_size, seek_offset
//   out_ch   out  valid/ready    found, slot_index, found_handle, found_size,
//                                byte_in_entry
//
// an add writes its slot and clears the result register, which is loaded into the output
// register once that is free; a find walks the occupied slots from the oldest, ending early
// on a hit, through the single slot memory read port, one slot per cycle
// reset is synchronous and clears the pointers and full flag; slot memory is not cleared
// one word is in work at a time; the next is accepted once the previous result sits
// in the output register, where it holds while out_ch.ready is low
`timescale 1ns / 1ps

module overwriting_ring_with_offset_search #(
  parameter int SLOTS = orws_pkg::SLOTS_DEFAULT
) (
  input logic       clk,
  input logic       rst_n,
  orws_in_if.sink   in_ch,
  orws_out_if.source out_ch
);
  import orws_pkg::*;

  in_word_t   in_word;
  out_word_t  out_word;
  dp_cmd_t    cmd;
  dp_status_t status;

  // request word from the channel
  always_comb begin
    in_word.action       = in_ch.action;
    in_word.entry_handle = in_ch.entry_handle;
    in_word.entry_size   = in_ch.entry_size;
    in_word.seek_offset  = in_ch.seek_offset;
  end

  // controller
  orws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // datapath
  orws_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cmd      (cmd),
    .status   (status),
    .out_word (out_word)
  );

  // result word to the channel
  assign out_ch.found         = out_word.found;
  assign out_ch.slot_index    = out_word.slot_index;
  assign out_ch.found_handle  = out_word.found_handle;
  assign out_ch.found_size    = out_word.found_size;
  assign out_ch.byte_in_entry = out_word.byte_in_entry;

endmodule
